### hw/rtl/bpq_pkg.sv
// Shared sizes, codes and types of the bounded priority queue.
package bpq_pkg;

	localparam int DEPTH      = 16;
	localparam int PRIO_WIDTH = 8;
	localparam int TAG_WIDTH  = 16;

	// Entry count, able to hold DEPTH itself.
	localparam int CNT_W = $clog2(DEPTH + 1);
	// Width of the capacity register.
	localparam int CAP_W = 5;
	// Common width for comparing the count with the capacity.
	localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam int IN_DATA_W  = ((PRIO_WIDTH + TAG_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((PRIO_WIDTH + TAG_WIDTH + CNT_W + 7) / 8) * 8;
	localparam int IN_USER_W  = 1;
	localparam int OUT_USER_W = 2;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_PUSH_OK    = 2'd0,
		ST_PUSH_DROP  = 2'd1,
		ST_POP_OK     = 2'd2,
		ST_POP_EMPTY  = 2'd3
	} bpq_status_t;

	// Row-wide update command seen by every cell in the same cycle.
	typedef struct packed {
		logic push;
		logic pop;
	} bpq_ctrl_t;

endpackage

### hw/rtl/bpq_cell.sv
// One slot of the sorted row: holds an entry and shifts it left or right.
module bpq_cell (
	input  logic                            clk,
	input  bpq_pkg::bpq_ctrl_t              ctrl,
	input  logic                            slot_valid,
	input  logic [bpq_pkg::PRIO_WIDTH-1:0]  new_prio,
	input  logic [bpq_pkg::TAG_WIDTH-1:0]   new_tag,
	input  logic                            left_lt,
	input  logic [bpq_pkg::PRIO_WIDTH-1:0]  left_prio,
	input  logic [bpq_pkg::TAG_WIDTH-1:0]   left_tag,
	input  logic [bpq_pkg::PRIO_WIDTH-1:0]  right_prio,
	input  logic [bpq_pkg::TAG_WIDTH-1:0]   right_tag,
	output logic                            lt,
	output logic [bpq_pkg::PRIO_WIDTH-1:0]  prio,
	output logic [bpq_pkg::TAG_WIDTH-1:0]   tag
);

	logic [bpq_pkg::PRIO_WIDTH-1:0] prio_q;
	logic [bpq_pkg::TAG_WIDTH-1:0]  tag_q;

	// An empty slot or a strictly lower priority gives way to the new entry.
	// Equal priority keeps its place, so equal entries stay first in, first out.
	assign lt = !slot_valid || (prio_q < new_prio);

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			prio_q <= right_prio;
			tag_q  <= right_tag;
		end else if (ctrl.push && lt) begin
			if (left_lt) begin
				prio_q <= left_prio;
				tag_q  <= left_tag;
			end else begin
				prio_q <= new_prio;
				tag_q  <= new_tag;
			end
		end
	end

	assign prio = prio_q;
	assign tag  = tag_q;

endmodule

### hw/rtl/bounded_priority_queue.sv
// Top level of the bounded priority queue: cell row, count, capacity and output beat.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: mode; tdata: priority_req, tag
//  m_      | out | m_tvalid/m_tready  | tuser: status; tdata: prio, tag, fill
//  cfg_    | in  | cfg_we             | cfg_wdata: capacity_limit
//
// Barring an output stall, one item is taken per cycle: every cell compares the new
// priority with its own and shifts in the same edge; only the row sets the rate.
// The result beat appears the cycle after the item is accepted.
// Reset clears the entry count and sets the capacity to 16; entries need no clearing.
// While a result beat waits with m_tready low, s_tready is low.
module bounded_priority_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bpq_pkg::IN_DATA_W-1:0]    s_tdata,  // priority_req, tag
	input  logic [bpq_pkg::IN_USER_W-1:0]    s_tuser,  // mode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bpq_pkg::OUT_DATA_W-1:0]   m_tdata,  // out_priority, out_tag, fill_count
	output logic [bpq_pkg::OUT_USER_W-1:0]   m_tuser,  // status
	input  logic                             cfg_we,
	input  logic [bpq_pkg::CAP_W-1:0]        cfg_wdata
);

	localparam int PW = bpq_pkg::PRIO_WIDTH;
	localparam int TW = bpq_pkg::TAG_WIDTH;
	localparam int CW = bpq_pkg::CNT_W;

	logic [bpq_pkg::CAP_W-1:0] cap_q;
	logic [CW-1:0]             occ_q;
	logic [CW-1:0]             occ_d;
	logic [CW-1:0]             eff_cap;

	logic                      out_valid_q;
	bpq_pkg::bpq_status_t      out_status_q;
	logic [PW-1:0]             out_prio_q;
	logic [TW-1:0]             out_tag_q;
	logic [CW-1:0]             out_fill_q;

	logic                      in_fire;
	logic                      in_mode;
	logic [PW-1:0]             in_prio;
	logic [TW-1:0]             in_tag;
	bpq_pkg::bpq_ctrl_t        ctrl;
	bpq_pkg::bpq_status_t      status_d;

	logic [PW-1:0]             cell_prio [bpq_pkg::DEPTH];
	logic [TW-1:0]             cell_tag  [bpq_pkg::DEPTH];
	logic [bpq_pkg::DEPTH-1:0] cell_lt;
	logic [bpq_pkg::DEPTH-1:0] cell_valid;

	assign in_mode = s_tuser[0];
	assign in_prio = s_tdata[PW-1:0];
	assign in_tag  = s_tdata[PW+TW-1:PW];

	assign s_tready = !out_valid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;

	// A capacity above the row length acts as the row length.
	always_comb begin
		if (bpq_pkg::CMP_W'(cap_q) > bpq_pkg::CMP_W'(bpq_pkg::DEPTH)) begin
			eff_cap = CW'(bpq_pkg::DEPTH);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	always_comb begin
		ctrl.push = 1'b0;
		ctrl.pop  = 1'b0;
		occ_d     = occ_q;
		if (in_mode == bpq_pkg::MODE_PUSH) begin
			if (occ_q < eff_cap) begin
				status_d  = bpq_pkg::ST_PUSH_OK;
				ctrl.push = in_fire;
				occ_d     = occ_q + CW'(1);
			end else begin
				status_d  = bpq_pkg::ST_PUSH_DROP;
			end
		end else begin
			if (occ_q != '0) begin
				status_d  = bpq_pkg::ST_POP_OK;
				ctrl.pop  = in_fire;
				occ_d     = occ_q - CW'(1);
			end else begin
				status_d  = bpq_pkg::ST_POP_EMPTY;
			end
		end
	end

	genvar i;
	generate
		for (i = 0; i < bpq_pkg::DEPTH; i++) begin : g_row
			logic          l_lt;
			logic [PW-1:0] l_prio;
			logic [TW-1:0] l_tag;
			logic [PW-1:0] r_prio;
			logic [TW-1:0] r_tag;

			assign cell_valid[i] = occ_q > CW'(i);

			if (i == 0) begin : g_first
				assign l_lt   = 1'b0;
				assign l_prio = '0;
				assign l_tag  = '0;
			end else begin : g_inner
				assign l_lt   = cell_lt[i-1];
				assign l_prio = cell_prio[i-1];
				assign l_tag  = cell_tag[i-1];
			end

			if (i == bpq_pkg::DEPTH - 1) begin : g_last
				assign r_prio = '0;
				assign r_tag  = '0;
			end else begin : g_body
				assign r_prio = cell_prio[i+1];
				assign r_tag  = cell_tag[i+1];
			end

			bpq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.slot_valid (cell_valid[i]),
				.new_prio   (in_prio),
				.new_tag    (in_tag),
				.left_lt    (l_lt),
				.left_prio  (l_prio),
				.left_tag   (l_tag),
				.right_prio (r_prio),
				.right_tag  (r_tag),
				.lt         (cell_lt[i]),
				.prio       (cell_prio[i]),
				.tag        (cell_tag[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= bpq_pkg::CAP_RESET;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (in_fire) begin
				occ_q       <= occ_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_status_q <= status_d;
			out_fill_q   <= occ_d;
			if (status_d == bpq_pkg::ST_POP_OK) begin
				out_prio_q <= cell_prio[0];
				out_tag_q  <= cell_tag[0];
			end else begin
				out_prio_q <= '0;
				out_tag_q  <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = bpq_pkg::OUT_DATA_W'({out_fill_q, out_tag_q, out_prio_q});

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(bpq_pkg::DEPTH))
		else $error("entry count beyond row length");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_mode == bpq_pkg::MODE_POP && occ_q == '0)
		|=> (m_tvalid && m_tuser == bpq_pkg::ST_POP_EMPTY && occ_q == '0))
		else $error("pop on empty queue not reported");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_mode == bpq_pkg::MODE_PUSH && occ_q < eff_cap)
		|=> (occ_q == $past(occ_q) + CW'(1) && m_tdata[PW+TW+CW-1:PW+TW] == occ_q))
		else $error("accepted push did not raise the entry count");

	a_front_order: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q >= CW'(2)) |-> (cell_prio[0] >= cell_prio[1]))
		else $error("front entries out of priority order");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for the bounded priority queue: directed and random beats.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int PW = bpq_pkg::PRIO_WIDTH;
	localparam int TW = bpq_pkg::TAG_WIDTH;
	localparam int CW = bpq_pkg::CNT_W;

	typedef struct {
		logic          mode;
		logic [PW-1:0] prio;
		logic [TW-1:0] tag;
	} item_t;

	typedef struct packed {
		logic [PW-1:0] prio;
		logic [TW-1:0] tag;
	} entry_t;

	typedef struct {
		bpq_pkg::bpq_status_t status;
		logic [PW-1:0]        prio;
		logic [TW-1:0]        tag;
		logic [CW-1:0]        fill;
	} outcome_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [bpq_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [bpq_pkg::IN_USER_W-1:0]  s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [bpq_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [bpq_pkg::OUT_USER_W-1:0] m_tuser;
	logic                           cfg_we = 1'b0;
	logic [bpq_pkg::CAP_W-1:0]      cfg_wdata = '0;

	item_t                     item_backlog[$];
	outcome_t                  pending_outcomes[$];
	entry_t                    held[$];
	logic [bpq_pkg::CAP_W-1:0] capacity = bpq_pkg::CAP_RESET;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_cycles = 0;
	int failures = 0;
	int beats_in = 0;
	int cap_writes = 0;
	int status_tally[4] = '{0, 0, 0, 0};

	bounded_priority_queue uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one item to the shadow store and returns the result beat it must produce.
	function automatic outcome_t apply_item(logic mode, logic [PW-1:0] prio,
			logic [TW-1:0] tag);
		outcome_t r;
		entry_t   e;
		int       pos;
		int       room;
		r.status = bpq_pkg::ST_PUSH_OK;
		r.prio = '0;
		r.tag = '0;
		room = (capacity > bpq_pkg::DEPTH) ? bpq_pkg::DEPTH : int'(capacity);
		if (mode == bpq_pkg::MODE_PUSH) begin
			if (held.size() < room) begin
				// A new entry goes behind every entry of equal or higher priority.
				pos = 0;
				while (pos < held.size() && held[pos].prio >= prio)
					pos++;
				e.prio = prio;
				e.tag = tag;
				held.insert(pos, e);
			end else begin
				r.status = bpq_pkg::ST_PUSH_DROP;
			end
		end else if (held.size() != 0) begin
			e = held[0];
			held.delete(0);
			r.status = bpq_pkg::ST_POP_OK;
			r.prio = e.prio;
			r.tag = e.tag;
		end else begin
			r.status = bpq_pkg::ST_POP_EMPTY;
		end
		r.fill = CW'(held.size());
		return r;
	endfunction

	always @(posedge clk) begin : drive
		item_t    it;
		outcome_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				nxt = apply_item(s_tuser[0], s_tdata[PW-1:0], s_tdata[PW+TW-1:PW]);
				pending_outcomes.insert(pending_outcomes.size(), nxt);
				beats_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					it = item_backlog[0];
					item_backlog.delete(0);
					s_tvalid <= 1'b1;
					s_tuser <= bpq_pkg::IN_USER_W'(it.mode);
					s_tdata <= bpq_pkg::IN_DATA_W'({it.tag, it.prio});
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// A change of hold_req starts one long stretch with m_tready low.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check
		outcome_t      want;
		logic [PW-1:0] got_prio;
		logic [TW-1:0] got_tag;
		logic [CW-1:0] got_fill;
		if (arst_n && m_tvalid && m_tready) begin
			got_prio = m_tdata[PW-1:0];
			got_tag = m_tdata[PW+TW-1:PW];
			got_fill = m_tdata[PW+TW+CW-1:PW+TW];
			if (pending_outcomes.size() == 0) begin
				$error("result beat with no item outstanding");
				failures++;
			end else begin
				want = pending_outcomes[0];
				pending_outcomes.delete(0);
				status_tally[want.status]++;
				if (m_tuser != want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tuser);
					failures++;
				end
				if (got_prio != want.prio) begin
					$error("out_priority: expected %0d, actual %0d", want.prio, got_prio);
					failures++;
				end
				if (got_tag != want.tag) begin
					$error("out_tag: expected 0x%04h, actual 0x%04h", want.tag, got_tag);
					failures++;
				end
				if (got_fill != want.fill) begin
					$error("fill_count: expected %0d, actual %0d", want.fill, got_fill);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("no beat moved for %0d cycles", STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic add_item(input logic mode, input logic [PW-1:0] prio,
			input logic [TW-1:0] tag);
		item_t it;
		it.mode = mode;
		it.prio = prio;
		it.tag = tag;
		item_backlog.insert(item_backlog.size(), it);
	endtask

	// Waits until every queued item has gone in and every result has been checked.
	task automatic settle();
		while (item_backlog.size() != 0 || s_tvalid || pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [bpq_pkg::CAP_W-1:0] value);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity = value;
		cap_writes++;
	endtask

	// Bursts that lean toward pushes, lean toward pops or stay even sweep the fill level from empty to full.
	task automatic random_phase(input int count);
		int            done;
		int            burst;
		int            push_pct;
		logic [PW-1:0] prio;
		done = 0;
		while (done < count) begin
			burst = $urandom_range(40, 4);
			case ($urandom_range(2))
				0: push_pct = 80;
				1: push_pct = 20;
				default: push_pct = 50;
			endcase
			repeat (burst) begin
				// Narrow priorities give many ties, so equal-priority order gets exercised.
				case ($urandom_range(3))
					0: prio = PW'($urandom_range(3));
					1: prio = $urandom_range(1) ? '1 : '0;
					default: prio = PW'($urandom);
				endcase
				add_item(($urandom_range(99) < push_pct) ? bpq_pkg::MODE_PUSH
					: bpq_pkg::MODE_POP, prio, TW'($urandom));
				done++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 10;
		recv_idle_pct = 82;

		// Reset capacity: empty pops, extreme fields and ties drained in order.
		add_item(bpq_pkg::MODE_POP, 8'h00, 16'h0000);
		add_item(bpq_pkg::MODE_PUSH, 8'hFF, 16'hFFFF);
		add_item(bpq_pkg::MODE_PUSH, 8'h00, 16'h0000);
		add_item(bpq_pkg::MODE_PUSH, 8'hFF, 16'h1234);
		add_item(bpq_pkg::MODE_PUSH, 8'h80, 16'hAAAA);
		add_item(bpq_pkg::MODE_PUSH, 8'h80, 16'h5555);
		add_item(bpq_pkg::MODE_PUSH, 8'h00, 16'hFFFF);
		repeat (6) add_item(bpq_pkg::MODE_POP, 8'hFF, 16'hFFFF);
		add_item(bpq_pkg::MODE_POP, 8'h00, 16'h0000);

		// Zero capacity drops every push.
		set_capacity(5'd0);
		add_item(bpq_pkg::MODE_PUSH, 8'h07, 16'h0101);
		add_item(bpq_pkg::MODE_POP, 8'h00, 16'h0000);

		// A small capacity reaches the full store quickly.
		set_capacity(5'd2);
		add_item(bpq_pkg::MODE_PUSH, 8'h01, 16'h0001);
		add_item(bpq_pkg::MODE_PUSH, 8'h02, 16'h0002);
		add_item(bpq_pkg::MODE_PUSH, 8'h03, 16'h0003);
		add_item(bpq_pkg::MODE_POP, 8'h00, 16'h0000);
		add_item(bpq_pkg::MODE_POP, 8'h00, 16'h0000);

		set_capacity(5'd31);
		random_phase(330);
		set_capacity(5'd16);
		random_phase(330);

		set_capacity(5'd1);
		send_idle_pct = 82;
		recv_idle_pct = 10;
		random_phase(330);
		set_capacity(5'd9);
		random_phase(330);

		set_capacity(5'd17);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req++;
		random_phase(330);
		set_capacity(5'd5);
		random_phase(330);
		set_capacity(5'd0);
		random_phase(50);
		settle();

		$display("Ran %0d items: %0d held, %0d dropped, %0d popped, %0d empty pops.",
			beats_in, status_tally[bpq_pkg::ST_PUSH_OK],
			status_tally[bpq_pkg::ST_PUSH_DROP], status_tally[bpq_pkg::ST_POP_OK],
			status_tally[bpq_pkg::ST_POP_EMPTY]);
		$display("Capacity set %0d times from 0 to 31; idling on each side, one long stall.",
			cap_writes);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
